>>> src/xbmd_pkg.sv
// ============================================================================
// xbmd_pkg
// Shared types and constants for the byte multiply/divide unit.
// ============================================================================
package xbmd_pkg;

    // Operation codes carried by each input beat
    typedef enum logic [1:0] {
        CMD_MUL  = 2'd0,
        CMD_IMUL = 2'd1,
        CMD_DIV  = 2'd2,
        CMD_IDIV = 2'd3
    } t_cmd;

    // Input beat
    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] ax_in;
        logic [7:0]  operand;
    } t_xbmd_in;

    // Result beat
    typedef struct packed {
        logic [15:0] ax_out;
        logic        carry_flag;
        logic        overflow_flag;
        logic        sign_flag;
        logic        zero_flag;
        logic        parity_flag;
        logic        flags_written;
        logic        divide_error;
    } t_xbmd_out;

    // Working data handed from cell to cell
    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] ax;
        logic [15:0] prod;
        logic        dvs_zero;
        logic        neg_q;
        logic        neg_r;
        logic [7:0]  dvs;
        logic [7:0]  rem;
        logic [15:0] dq;
    } t_xbmd_lane;

    // One cell per quotient bit of the 16-bit dividend magnitude
    localparam int DIV_STEPS    = 16;
    // Prepare stage, divider cells, result stage
    localparam int XBMD_LATENCY = DIV_STEPS + 2;

endpackage

>>> src/x86_byte_mul_div_unit.sv
// ============================================================================
// x86_byte_mul_div_unit
// Byte-form MUL, IMUL, DIV and IDIV on AX with an 8-bit source operand.
// ============================================================================
// Usage: a new beat may start in every cycle; busy is high only while reset
// is applied and for the cycle after. Every beat returns exactly one result,
// shown with o_done for a single cycle once the beat has passed through
// one entry stage, a chain of sixteen one-bit restoring-division cells, and
// one result stage. Multiplies travel the same chain so results come out in
// start order. The receiver cannot stall, so results must be taken when
// o_done is high.
module x86_byte_mul_div_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  xbmd_pkg::t_xbmd_in  i_item,
    output logic                o_done,
    output xbmd_pkg::t_xbmd_out o_result
);
    import xbmd_pkg::*;

    logic       r_busy;
    logic       w_valid [DIV_STEPS+1];
    t_xbmd_lane w_lane  [DIV_STEPS+1];

    // Hold off starts while reset is applied
    always_ff @(posedge i_clk) begin
        r_busy <= ~i_rst_n;
    end
    assign o_busy = r_busy;

    xbmd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !r_busy),
        .i_item  (i_item),
        .o_valid (w_valid[0]),
        .o_lane  (w_lane[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        xbmd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    xbmd_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[DIV_STEPS]),
        .i_lane   (w_lane[DIV_STEPS]),
        .o_valid  (o_done),
        .o_result (o_result)
    );

endmodule

>>> src/xbmd_prep.sv
// ============================================================================
// xbmd_prep
// Entry stage: forms the 8x8 product and the operand magnitudes and signs
// that seed the divider chain.
// ============================================================================
module xbmd_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  xbmd_pkg::t_xbmd_in  i_item,
    output logic                o_valid,
    output xbmd_pkg::t_xbmd_lane o_lane
);
    import xbmd_pkg::*;

    logic       r_valid;
    t_xbmd_lane r_lane;
    t_xbmd_lane n_lane;
    logic       neg_dvd;
    logic       neg_dvs;
    logic [7:0] al;

    // Build the lane: product plus divider seed
    always_comb begin
        al      = i_item.ax_in[7:0];
        neg_dvd = (i_item.cmd == CMD_IDIV) && i_item.ax_in[15];
        neg_dvs = (i_item.cmd == CMD_IDIV) && i_item.operand[7];

        n_lane.cmd = i_item.cmd;
        n_lane.ax  = i_item.ax_in;
        if (i_item.cmd == CMD_IMUL) begin
            n_lane.prod = 16'($signed(al) * $signed(i_item.operand));
        end else begin
            n_lane.prod = 16'(al * i_item.operand);
        end
        n_lane.dvs_zero = (i_item.operand == 8'd0);
        n_lane.neg_q    = neg_dvd ^ neg_dvs;
        n_lane.neg_r    = neg_dvd;
        n_lane.dvs      = neg_dvs ? (~i_item.operand + 8'd1) : i_item.operand;
        n_lane.rem      = 8'd0;
        n_lane.dq       = neg_dvd ? (~i_item.ax_in + 16'd1) : i_item.ax_in;
    end

    // Hold valid under reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

>>> src/xbmd_div_cell.sv
// ============================================================================
// xbmd_div_cell
// One restoring-division step: shift in a dividend bit, trial subtract,
// shift in a quotient bit, and pass the lane to the next cell.
// ============================================================================
module xbmd_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  xbmd_pkg::t_xbmd_lane i_lane,
    output logic                 o_valid,
    output xbmd_pkg::t_xbmd_lane o_lane
);
    import xbmd_pkg::*;

    logic       r_valid;
    t_xbmd_lane r_lane;
    t_xbmd_lane n_lane;
    logic [8:0] trial;
    logic       q_bit;

    // Trial subtract of the divisor from the widened partial remainder
    always_comb begin
        n_lane = i_lane;
        trial  = {i_lane.rem, i_lane.dq[15]};
        q_bit  = (trial >= {1'b0, i_lane.dvs});
        if (q_bit) begin
            n_lane.rem = 8'(trial - {1'b0, i_lane.dvs});
        end else begin
            n_lane.rem = trial[7:0];
        end
        n_lane.dq = {i_lane.dq[14:0], q_bit};
    end

    // Advance the lane every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

>>> src/xbmd_post.sv
// ============================================================================
// xbmd_post
// Result stage: multiply flags, divide sign fix-up and overflow checks.
// ============================================================================
module xbmd_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  xbmd_pkg::t_xbmd_lane i_lane,
    output logic                 o_valid,
    output xbmd_pkg::t_xbmd_out  o_result
);
    import xbmd_pkg::*;

    logic        r_valid;
    t_xbmd_out   r_result;
    t_xbmd_out   n_result;
    logic [15:0] q_signed;
    logic [7:0]  r_signed;
    logic        q_over;
    logic        cf;

    always_comb begin
        n_result = '0;
        n_result.ax_out = i_lane.ax;
        cf       = 1'b0;
        q_over   = 1'b0;
        q_signed = i_lane.neg_q ? (~i_lane.dq + 16'd1) : i_lane.dq;
        r_signed = i_lane.neg_r ? (~i_lane.rem + 8'd1) : i_lane.rem;

        case (i_lane.cmd)
            CMD_MUL, CMD_IMUL: begin
                // Multiply: flags from the low byte, carry from the high byte
                if (i_lane.cmd == CMD_MUL) begin
                    cf = |i_lane.prod[15:8];
                end else begin
                    cf = (i_lane.prod[15:8] != {8{i_lane.prod[7]}});
                end
                n_result.ax_out        = i_lane.prod;
                n_result.carry_flag    = cf;
                n_result.overflow_flag = cf;
                n_result.sign_flag     = i_lane.prod[7];
                n_result.zero_flag     = (i_lane.prod[7:0] == 8'd0);
                n_result.parity_flag   = ~^i_lane.prod[7:0];
                n_result.flags_written = 1'b1;
            end
            CMD_DIV: begin
                // Unsigned quotient must fit in a byte
                q_over = |i_lane.dq[15:8];
                if (i_lane.dvs_zero || q_over) begin
                    n_result.divide_error = 1'b1;
                end else begin
                    n_result.ax_out = {i_lane.rem, i_lane.dq[7:0]};
                end
            end
            default: begin
                // Signed quotient must lie in -128..127
                if (i_lane.neg_q) begin
                    q_over = (i_lane.dq > 16'd128);
                end else begin
                    q_over = (i_lane.dq > 16'd127);
                end
                if (i_lane.dvs_zero || q_over) begin
                    n_result.divide_error = 1'b1;
                end else begin
                    n_result.ax_out = {r_signed, q_signed[7:0]};
                end
            end
        endcase
    end

    // Register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> src/xbmd_checker.sv
// ============================================================================
// xbmd_checker
// Port-level checks for the byte multiply/divide unit, bound to the top.
// ============================================================================
module xbmd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input xbmd_pkg::t_xbmd_in  i_item,
    input logic                o_done,
    input xbmd_pkg::t_xbmd_out o_result
);
    import xbmd_pkg::*;

    // Every accepted beat yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##XBMD_LATENCY o_done)
        else $error("result beat missing after start");

    // A faulted divide leaves AX as it came in
    a_err_ax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.divide_error) |->
            (o_result.ax_out == $past(i_item.ax_in, XBMD_LATENCY)))
        else $error("divide error changed AX");

    // Divides report no flags and multiplies never fault
    a_div_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.flags_written) |->
            (!o_result.carry_flag && !o_result.overflow_flag &&
             !o_result.sign_flag && !o_result.zero_flag && !o_result.parity_flag))
        else $error("flags set on divide");

    a_mul_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.flags_written) |->
            (!o_result.divide_error &&
             (o_result.carry_flag == o_result.overflow_flag)))
        else $error("multiply flag mismatch");

endmodule

bind x86_byte_mul_div_unit xbmd_checker u_xbmd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);
